// ===== sv/ldcd_pkg.sv =====
// Package for the laserdisc command decoder: payload types, command codes and digit decoding.
package ldcd_pkg;

   localparam int MAX_DIGITS_DEFAULT = 5;

   // Command byte codes other than digits.
   localparam logic [7:0] CODE_AUDIO1   = 8'hF4;
   localparam logic [7:0] CODE_AUDIO2   = 8'hFC;
   localparam logic [7:0] CODE_SPEED1X  = 8'hA3;
   localparam logic [7:0] CODE_AUTOSTOP = 8'hF3;
   localparam logic [7:0] CODE_PLAY     = 8'hFD;
   localparam logic [7:0] CODE_SEARCH   = 8'hF7;
   localparam logic [7:0] CODE_PAUSE    = 8'hFB;
   localparam logic [7:0] CODE_REJECT   = 8'hF9;
   localparam logic [7:0] CODE_NO_ENTRY = 8'hFF;

   // Digit byte codes.
   localparam logic [7:0] CODE_DIGIT0 = 8'h3F;
   localparam logic [7:0] CODE_DIGIT1 = 8'h0F;
   localparam logic [7:0] CODE_DIGIT2 = 8'h8F;
   localparam logic [7:0] CODE_DIGIT3 = 8'h4F;
   localparam logic [7:0] CODE_DIGIT4 = 8'h2F;
   localparam logic [7:0] CODE_DIGIT5 = 8'hAF;
   localparam logic [7:0] CODE_DIGIT6 = 8'h6F;
   localparam logic [7:0] CODE_DIGIT7 = 8'h1F;
   localparam logic [7:0] CODE_DIGIT8 = 8'h9F;
   localparam logic [7:0] CODE_DIGIT9 = 8'h5F;

   // Transaction kinds on the request channel.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_POLL  = 1'b1;

   // Player status codes at a poll.
   localparam logic [1:0] STATUS_BUSY   = 2'd0;
   localparam logic [1:0] STATUS_PAUSED = 2'd1;
   localparam logic [1:0] STATUS_ERROR  = 2'd2;

   // Action codes.
   localparam logic [3:0] ACT_NONE       = 4'd0;
   localparam logic [3:0] ACT_PLAY       = 4'd1;
   localparam logic [3:0] ACT_PAUSE      = 4'd2;
   localparam logic [3:0] ACT_SPEED1X    = 4'd3;
   localparam logic [3:0] ACT_SEARCH     = 4'd4;
   localparam logic [3:0] ACT_AUDIO1_ON  = 4'd5;
   localparam logic [3:0] ACT_AUDIO1_OFF = 4'd6;
   localparam logic [3:0] ACT_AUDIO2_ON  = 4'd7;
   localparam logic [3:0] ACT_AUDIO2_OFF = 4'd8;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  byte_value;
      logic        search_accepted;
      logic [1:0]  player_status;
      logic [15:0] current_frame;
   } ldcd_req_type;

   typedef struct packed {
      logic        ready_res;
      logic [3:0]  action;
      logic [15:0] action_frame;
      logic [2:0]  action_digits;
      logic        unsupported;
   } ldcd_rsp_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] digit;
   } ldcd_digit_type;

   // Maps a command byte to a decimal digit; valid is low for non-digit bytes.
   function automatic ldcd_digit_type decode_digit(input logic [7:0] code);
      ldcd_digit_type res;
      res.valid = 1'b1;
      unique case (code)
         CODE_DIGIT0: res.digit = 4'd0;
         CODE_DIGIT1: res.digit = 4'd1;
         CODE_DIGIT2: res.digit = 4'd2;
         CODE_DIGIT3: res.digit = 4'd3;
         CODE_DIGIT4: res.digit = 4'd4;
         CODE_DIGIT5: res.digit = 4'd5;
         CODE_DIGIT6: res.digit = 4'd6;
         CODE_DIGIT7: res.digit = 4'd7;
         CODE_DIGIT8: res.digit = 4'd8;
         CODE_DIGIT9: res.digit = 4'd9;
         default: begin
            res.valid = 1'b0;
            res.digit = 4'd0;
         end
      endcase
      return res;
   endfunction

endpackage

// ===== sv/ldcd_digit_value.sv =====
// Decimal value of the stored digits, modulo 65536.
module ldcd_digit_value
   import ldcd_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1)
) (
   input  logic [3:0]       digits [MAX_DIGITS],
   input  logic [CNT_W-1:0] count,
   output logic [15:0]      value
);

   // Horner chain; each step is a multiply by ten as two shifts and an add.
   always_comb begin
      logic [15:0] acc;
      acc = 16'd0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (CNT_W'(i) < count) begin
            acc = (acc << 3) + (acc << 1) + {12'd0, digits[i]};
         end
      end
      value = acc;
   end

endmodule

// ===== sv/laserdisc_command_decoder.sv =====
// Top level of the laserdisc command decoder.
//
// The host side offers one transaction per request on the req_ channel: either a
// command byte write or a poll of the ready line, together with the player's search
// acceptance, status and current frame. Every request produces exactly one response
// transaction on the rsp_ channel with the ready line level, the player action to
// carry out, and for a search the target frame and digit count.
//
// Both channels use valid/ready. A request taken at one clock edge is held in the
// request register, decoded against the block state, and its response is registered
// in the response register. The decode is a single pass of logic between the two
// registers, with the decimal conversion of the stored digits as the longest path, so
// while the receiver does not stall a new request is taken in every cycle and the
// sustained rate is one transaction per cycle.
//
// When the receiver stalls, the response register holds its transaction and one more
// request may still be taken into the request register; after that req_ready stays
// low until the response is taken. Reset empties both registers, clears the digit
// count, search flag and auto-stop target, drives the ready line to not ready and
// turns both audio channels on.
module laserdisc_command_decoder
   import ldcd_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ldcd_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ldcd_rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS);

   // Pipeline registers.
   logic         s1_valid_ff, s1_valid_in;
   ldcd_req_type s1_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   ldcd_rsp_type rsp_ff, rsp_in;

   // Block state.
   logic [3:0]       store_ff [MAX_DIGITS];
   logic [CNT_W-1:0] digit_count_ff, digit_count_in;
   logic             ready_level_ff, ready_level_in;
   logic             search_pending_ff, search_pending_in;
   logic [15:0]      autostop_ff, autostop_in;
   logic             audio1_ff, audio1_in;
   logic             audio2_ff, audio2_in;

   logic           out_free;
   logic           advance;
   logic           push;
   logic           store_full;
   ldcd_digit_type dec;
   logic [15:0]    digit_val;
   logic           audio_bit;

   // The response register moves when it is empty or being taken; the request
   // register empties into it at the same time.
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign advance      = s1_valid_ff && out_free;
   assign req_ready    = !s1_valid_ff || out_free;
   assign s1_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign dec        = decode_digit(s1_ff.byte_value);
   assign store_full = (digit_count_ff == CNT_FULL);
   assign push       = advance && (s1_ff.cmd == CMD_WRITE) && dec.valid;
   assign audio_bit  = store_ff[0][0];

   ldcd_digit_value #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_digit_value (
      .digits(store_ff),
      .count (digit_count_ff),
      .value (digit_val)
   );

   // Decode of the registered request against the current state.
   always_comb begin
      digit_count_in    = digit_count_ff;
      ready_level_in    = ready_level_ff;
      search_pending_in = search_pending_ff;
      autostop_in       = autostop_ff;
      audio1_in         = audio1_ff;
      audio2_in         = audio2_ff;
      rsp_in            = '0;

      if (s1_ff.cmd == CMD_POLL) begin
         if (search_pending_ff) begin
            // A busy or undefined status leaves the search pending.
            if (s1_ff.player_status == STATUS_PAUSED) begin
               ready_level_in    = 1'b0;
               search_pending_in = 1'b0;
            end else if (s1_ff.player_status == STATUS_ERROR) begin
               ready_level_in    = 1'b1;
               search_pending_in = 1'b0;
            end
         end else if (autostop_ff != 16'd0 && s1_ff.current_frame >= autostop_ff) begin
            rsp_in.action = ACT_PAUSE;
            autostop_in   = 16'd0;
         end
      end else if (dec.valid) begin
         if (!store_full) begin
            digit_count_in = digit_count_ff + CNT_W'(1);
         end
      end else begin
         unique case (s1_ff.byte_value)
            CODE_AUDIO1: begin
               if (digit_count_ff == '0) begin
                  audio1_in = !audio1_ff;
               end else begin
                  audio1_in      = audio_bit;
                  digit_count_in = '0;
               end
               rsp_in.action = audio1_in ? ACT_AUDIO1_ON : ACT_AUDIO1_OFF;
            end
            CODE_AUDIO2: begin
               if (digit_count_ff == '0) begin
                  audio2_in = !audio2_ff;
               end else begin
                  audio2_in      = audio_bit;
                  digit_count_in = '0;
               end
               rsp_in.action = audio2_in ? ACT_AUDIO2_ON : ACT_AUDIO2_OFF;
            end
            CODE_SPEED1X: rsp_in.action = ACT_SPEED1X;
            CODE_AUTOSTOP: begin
               autostop_in    = digit_val;
               digit_count_in = '0;
               rsp_in.action  = ACT_PLAY;
            end
            CODE_PLAY: rsp_in.action = ACT_PLAY;
            CODE_SEARCH: begin
               rsp_in.action        = ACT_SEARCH;
               rsp_in.action_frame  = digit_val;
               rsp_in.action_digits = 3'(digit_count_ff);
               ready_level_in       = 1'b1;
               digit_count_in       = '0;
               if (s1_ff.search_accepted) begin
                  search_pending_in = 1'b1;
               end
            end
            CODE_PAUSE: rsp_in.action = ACT_PAUSE;
            CODE_REJECT, CODE_NO_ENTRY: rsp_in.action = ACT_NONE;
            default: rsp_in.unsupported = 1'b1;
         endcase
      end

      rsp_in.ready_res = ready_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         digit_count_ff    <= '0;
         ready_level_ff    <= 1'b1;
         search_pending_ff <= 1'b0;
         autostop_ff       <= 16'd0;
         audio1_ff         <= 1'b1;
         audio2_ff         <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            digit_count_ff    <= digit_count_in;
            ready_level_ff    <= ready_level_in;
            search_pending_ff <= search_pending_in;
            autostop_ff       <= autostop_in;
            audio1_ff         <= audio1_in;
            audio2_ff         <= audio2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Digit store: append while not full, otherwise shift out the oldest digit.
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_store
      if (i < MAX_DIGITS - 1) begin : g_mid
         always_ff @(posedge clock) begin
            if (push) begin
               if (store_full) begin
                  store_ff[i] <= store_ff[i+1];
               end else if (digit_count_ff[IDX_W-1:0] == IDX_W'(i)) begin
                  store_ff[i] <= dec.digit;
               end
            end
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            if (push && (store_full || digit_count_ff[IDX_W-1:0] == IDX_W'(i))) begin
               store_ff[i] <= dec.digit;
            end
         end
      end
   end

   // The digit count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= CNT_FULL)
      else $error("digit count exceeds store depth");

   // Frame and digit count are only given with a search action.
   a_search_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.action != ACT_SEARCH |->
         rsp_payload.action_frame == 16'd0 && rsp_payload.action_digits == 3'd0)
      else $error("search fields set without a search action");

   // A search always leaves the ready line at not ready.
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.action == ACT_SEARCH |-> rsp_payload.ready_res)
      else $error("search response shows ready");

   // An unknown byte produces no action.
   a_unsup_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.unsupported |-> rsp_payload.action == ACT_NONE)
      else $error("unsupported byte with an action");

   // A pending search is only settled by a poll.
   a_pending_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(search_pending_ff) |-> $past(advance && s1_ff.cmd == CMD_POLL))
      else $error("pending search cleared outside a poll");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the laserdisc command decoder: directed and random command streams.
module tb;
   import ldcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The digit store depth is the design default, so overflow happens at the sixth digit.
   localparam int STORE_DEPTH = MAX_DIGITS_DEFAULT;

   // The largest value a 2-bit status can carry. It is no defined status, so the block
   // must treat it as busy.
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   // A byte value that is neither a digit nor a command.
   localparam logic [7:0] CODE_UNKNOWN = 8'h00;

   // The run is aborted at this cycle count. A correct run ends well before it, even with
   // every transaction delayed by the longest sender gap and receiver stall.
   localparam int CYCLE_LIMIT = 400000;

   // Clock, reset and channel signals. Every input of the block is known from time zero.
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   ldcd_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   ldcd_rsp_type rsp_payload;

   // Shadow of the block state, advanced once for every request transaction accepted.
   logic [3:0]  held_digits [STORE_DEPTH];
   logic [3:0]  held_count = '0;
   logic        ready_line = 1'b1;
   logic        seek_pending = 1'b0;
   logic [15:0] stop_frame = '0;
   logic        audio1_on = 1'b1;
   logic        audio2_on = 1'b1;

   // Responses the block still owes, oldest first.
   ldcd_rsp_type owed_replies [$];

   int mismatches = 0;
   int requests_sent = 0;
   int cycle_count = 0;

   // Idling control. These are percentage chances of starting a burst of idle cycles on the
   // request side, drawn once per request, and of stall cycles on the response side, drawn per cycle.
   int gap_pct = 0;
   int stall_pct = 0;

   laserdisc_command_decoder #(
      .MAX_DIGITS(STORE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------

   // Command byte that stands for one decimal digit.
   function automatic logic [7:0] digit_code(input int d);
      case (d)
         0: return CODE_DIGIT0;
         1: return CODE_DIGIT1;
         2: return CODE_DIGIT2;
         3: return CODE_DIGIT3;
         4: return CODE_DIGIT4;
         5: return CODE_DIGIT5;
         6: return CODE_DIGIT6;
         7: return CODE_DIGIT7;
         8: return CODE_DIGIT8;
         default: return CODE_DIGIT9;
      endcase
   endfunction

   // Digit that a byte stands for, or -1 when the byte is no digit code.
   function automatic int digit_of_code(input logic [7:0] b);
      for (int d = 0; d < 10; d++) begin
         if (digit_code(d) == b) return d;
      end
      return -1;
   endfunction

   // Decimal value of the held digits, oldest digit most significant, wrapped to 16 bits.
   function automatic logic [15:0] held_value();
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < held_count; i++) begin
         v = v * 10 + held_digits[i];
      end
      return v[15:0];
   endfunction

   // Works out the response to one request and advances the shadow state past it.
   function automatic ldcd_rsp_type decode_command(input ldcd_req_type r);
      ldcd_rsp_type o;
      int           d;
      o = '0;
      if (r.cmd == CMD_POLL) begin
         // A pending search is settled by the player status; a busy or undefined status
         // leaves it pending. Only with no search pending does the auto-stop target count.
         if (seek_pending) begin
            if (r.player_status == STATUS_PAUSED) begin
               ready_line = 1'b0;
               seek_pending = 1'b0;
            end else if (r.player_status == STATUS_ERROR) begin
               ready_line = 1'b1;
               seek_pending = 1'b0;
            end
         end else if (stop_frame != 0 && r.current_frame >= stop_frame) begin
            o.action = ACT_PAUSE;
            stop_frame = '0;
         end
      end else begin
         d = digit_of_code(r.byte_value);
         if (d >= 0) begin
            // A full store drops its oldest digit to make room at the end.
            if (held_count < STORE_DEPTH) begin
               held_digits[held_count] = d[3:0];
               held_count++;
            end else begin
               for (int i = 1; i < STORE_DEPTH; i++) held_digits[i - 1] = held_digits[i];
               held_digits[STORE_DEPTH - 1] = d[3:0];
            end
         end else begin
            case (r.byte_value)
               // With digits held, the parity of the oldest one sets the channel (odd is
               // on) and the digits are consumed; without digits the channel toggles.
               CODE_AUDIO1: begin
                  if (held_count == 0) begin
                     audio1_on = !audio1_on;
                  end else begin
                     audio1_on = held_digits[0][0];
                     held_count = '0;
                  end
                  o.action = audio1_on ? ACT_AUDIO1_ON : ACT_AUDIO1_OFF;
               end
               CODE_AUDIO2: begin
                  if (held_count == 0) begin
                     audio2_on = !audio2_on;
                  end else begin
                     audio2_on = held_digits[0][0];
                     held_count = '0;
                  end
                  o.action = audio2_on ? ACT_AUDIO2_ON : ACT_AUDIO2_OFF;
               end
               CODE_SPEED1X: begin
                  o.action = ACT_SPEED1X;
               end
               CODE_AUTOSTOP: begin
                  stop_frame = held_value();
                  held_count = '0;
                  o.action = ACT_PLAY;
               end
               CODE_PLAY: begin
                  o.action = ACT_PLAY;
               end
               // A search always goes out and drives the line busy. A rejected one clears
               // the digits but leaves an earlier pending search as it was.
               CODE_SEARCH: begin
                  o.action = ACT_SEARCH;
                  o.action_frame = held_value();
                  o.action_digits = held_count[2:0];
                  ready_line = 1'b1;
                  if (r.search_accepted) seek_pending = 1'b1;
                  held_count = '0;
               end
               CODE_PAUSE: begin
                  o.action = ACT_PAUSE;
               end
               CODE_REJECT, CODE_NO_ENTRY: begin
               end
               default: begin
                  o.unsupported = 1'b1;
               end
            endcase
         end
      end
      o.ready_res = ready_line;
      return o;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   // Offers one request transaction and returns at the rising edge that accepts it. All
   // driving happens at falling edges. The task never lowers req_valid when it raises it
   // again for the next request in the same step, so back-to-back requests keep valid
   // high throughout.
   task automatic send_request(input ldcd_req_type r);
      @(negedge clock);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      owed_replies.push_back(decode_command(r));
      requests_sent++;
   endtask

   // Writes one command byte. The poll-only fields carry random values, which the block
   // must ignore. An accepted flag of -1 means a random one.
   task automatic write_byte(input logic [7:0] b, input int accepted = -1);
      ldcd_req_type r;
      r.cmd = CMD_WRITE;
      r.byte_value = b;
      r.search_accepted = (accepted < 0) ? 1'($urandom_range(0, 1)) : accepted[0];
      r.player_status = 2'($urandom_range(0, 3));
      r.current_frame = 16'($urandom);
      send_request(r);
   endtask

   // Polls the ready line with the given player status and frame; the byte is noise.
   task automatic poll_player(input logic [1:0] status, input logic [15:0] frame);
      ldcd_req_type r;
      r.cmd = CMD_POLL;
      r.byte_value = 8'($urandom_range(0, 255));
      r.search_accepted = 1'($urandom_range(0, 1));
      r.player_status = status;
      r.current_frame = frame;
      send_request(r);
   endtask

   // One random burst of host activity. Most bursts are well-formed: a run of digits
   // (sometimes longer than the store) closed by search, auto-stop or audio, with follow-up
   // polls after search or auto-stop. The rest is single polls, plain commands and raw noise bytes.
   task automatic send_random_sequence();
      int          pick;
      logic [15:0] near;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         repeat ($urandom_range(0, STORE_DEPTH + 2)) write_byte(digit_code($urandom_range(0, 9)));
         case ($urandom_range(0, 3))
            0: begin
               write_byte(CODE_SEARCH);
               repeat ($urandom_range(0, 3))
                  poll_player(2'($urandom_range(0, 3)), 16'($urandom));
            end
            1: begin
               // Frames around the new target hit the below, equal and above cases.
               write_byte(CODE_AUTOSTOP);
               repeat ($urandom_range(1, 3)) begin
                  near = stop_frame + 16'($urandom_range(0, 4)) - 16'd2;
                  poll_player(2'($urandom_range(0, 3)), near);
               end
            end
            2: write_byte(CODE_AUDIO1);
            default: write_byte(CODE_AUDIO2);
         endcase
      end else if (pick < 75) begin
         poll_player(2'($urandom_range(0, 3)), 16'($urandom));
      end else if (pick < 90) begin
         case ($urandom_range(0, 4))
            0: write_byte(CODE_PLAY);
            1: write_byte(CODE_PAUSE);
            2: write_byte(CODE_SPEED1X);
            3: write_byte(CODE_REJECT);
            default: write_byte(CODE_NO_ENTRY);
         endcase
      end else begin
         write_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Drops req_valid and waits until every owed response has come back.
   task automatic wait_for_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------------

   // The receiver stalls in bursts whose frequency is set by stall_pct.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic note_mismatch(input string field, input int unsigned want,
                                input int unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      end
   endtask

   // Every response transaction is matched against the oldest owed response, one field
   // at a time.
   always @(posedge clock) begin
      ldcd_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (owed_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response transaction %h with no request outstanding",
                        $realtime, rsp_payload);
            end
         end else begin
            want = owed_replies.pop_front();
            if (rsp_payload.ready_res !== want.ready_res)
               note_mismatch("ready_res", want.ready_res, rsp_payload.ready_res);
            if (rsp_payload.action !== want.action)
               note_mismatch("action", want.action, rsp_payload.action);
            if (rsp_payload.action_frame !== want.action_frame)
               note_mismatch("action_frame", want.action_frame, rsp_payload.action_frame);
            if (rsp_payload.action_digits !== want.action_digits)
               note_mismatch("action_digits", want.action_digits, rsp_payload.action_digits);
            if (rsp_payload.unsupported !== want.unsupported)
               note_mismatch("unsupported", want.unsupported, rsp_payload.unsupported);
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Out of reset: a poll reports not ready, an unknown byte is flagged, the two ignored
   // bytes do nothing, and the plain commands map to their actions.
   task automatic test_power_on_state();
      poll_player(STATUS_BUSY, 16'd0);
      write_byte(CODE_UNKNOWN);
      write_byte(CODE_REJECT);
      write_byte(CODE_NO_ENTRY);
      write_byte(CODE_SPEED1X);
      write_byte(CODE_PLAY);
      write_byte(CODE_PAUSE);
   endtask

   // Search with no digits, a full store that overflows and wraps past 16 bits, the
   // undefined status, a rejected search over a pending one, and settling by pause.
   task automatic test_search_directed();
      write_byte(CODE_SEARCH, 0);
      repeat (STORE_DEPTH) write_byte(CODE_DIGIT9);
      write_byte(CODE_DIGIT8);
      write_byte(CODE_SEARCH, 1);
      poll_player(STATUS_UNKNOWN, 16'hFFFF);
      write_byte(CODE_SEARCH, 0);
      poll_player(STATUS_PAUSED, 16'd0);
   endtask

   // Auto-stop target below and at the extreme of the frame range, then audio toggle and
   // audio set from an even digit.
   task automatic test_autostop_and_audio();
      write_byte(CODE_DIGIT5);
      write_byte(CODE_AUTOSTOP);
      poll_player(STATUS_BUSY, 16'd4);
      poll_player(STATUS_BUSY, 16'hFFFF);
      write_byte(CODE_AUDIO1);
      write_byte(CODE_DIGIT4);
      write_byte(CODE_AUDIO2);
   endtask

   // Random host activity until the given number of request transactions have gone out.
   task automatic test_random_sequences(input int count, input int gaps, input int stalls);
      int stop_at;
      gap_pct = gaps;
      stall_pct = stalls;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) send_random_sequence();
   endtask

   // The host goes quiet until the block has answered everything, several times over,
   // so that requests also arrive at an empty pipeline.
   task automatic test_drain_before_next();
      repeat (6) begin
         send_random_sequence();
         wait_for_replies();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_on_state();
      test_search_directed();
      test_autostop_and_audio();
      test_random_sequences(620, 25, 25);
      test_drain_before_next();
      test_random_sequences(500, 0, 50);
      // The closing stretch runs at full rate with no idling on either side.
      test_random_sequences(500, 0, 0);

      // Let any stray response show up before deciding.
      wait_for_replies();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
